// ===== src/imvp_pkg.sv =====
// ----------------------------------------------------------------------------
// imvp_pkg
// Shared types, constants and helpers for the incidence matrix-vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imvp_pkg;

  localparam int COLUMNS = 1024;
  localparam int ROWS    = 1024;
  localparam int COL_AW  = $clog2(COLUMNS);
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int IDX_W   = 10;
  localparam int Q_W     = 32;
  localparam int PROD_W  = 2 * Q_W;
  localparam int QUO_W   = PROD_W - 16;
  localparam int ARC_W   = 2 * IDX_W + 2;
  localparam logic signed [Q_W-1:0] SCALE_RESET = 32'sd65536;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CMD_WR_ARC = 3'd0,
    CMD_TIMES  = 3'd1,
    CMD_WR_ROW = 3'd2,
    CMD_TRANS  = 3'd3,
    CMD_RD_ROW = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ARC,
    S_QUO,
    S_SIDE,
    S_ROWD,
    S_ADD,
    S_DONE,
    S_RDOUT
  } state_t;

  typedef struct packed {
    logic [2:0]             command;
    logic [IDX_W-1:0]       column_index;
    logic [IDX_W-1:0]       minus_row;
    logic                   minus_present;
    logic [IDX_W-1:0]       plus_row;
    logic                   plus_present;
    logic [IDX_W-1:0]       row_index;
    logic signed [Q_W-1:0]  operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  result_value;
    logic                   saturated;
  } out_item_t;

  typedef struct packed {
    logic                   plus_present;
    logic [IDX_W-1:0]       plus_row;
    logic                   minus_present;
    logic [IDX_W-1:0]       minus_row;
  } arc_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic mul_en;
    logic mul_row;   // multiplicand: 1 row value, 0 operand
    logic quo_en;
    logic acc_load;
    logic acc_row;   // load source: 1 row value, 0 operand
    logic add_en;
    logic add_sub;
    logic sat_clr;
  } alu_ctrl_t;

  typedef struct packed {
    logic signed [Q_W-1:0] acc;
    logic                  sat;
    logic signed [Q_W-1:0] sum;
  } alu_stat_t;

  function automatic logic row_ok(input logic [IDX_W-1:0] r);
    return {{(32-IDX_W){1'b0}}, r} < 32'(ROWS);
  endfunction

  function automatic logic col_ok(input logic [IDX_W-1:0] c);
    return {{(32-IDX_W){1'b0}}, c} < 32'(COLUMNS);
  endfunction

endpackage

`default_nettype wire

// ===== src/imvp_ram.sv =====
// ----------------------------------------------------------------------------
// imvp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module imvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/imvp_alu.sv =====
// ----------------------------------------------------------------------------
// imvp_alu
// Shared datapath: Q16.16 multiply, truncating rescale, saturating add/sub.
// ----------------------------------------------------------------------------
`default_nettype none

module imvp_alu
  import imvp_pkg::*;
(
  input  wire logic                  clk,
  input  wire alu_ctrl_t             ctrl,
  input  wire logic signed [Q_W-1:0] scale,
  input  wire logic signed [Q_W-1:0] operand,
  input  wire logic signed [Q_W-1:0] row_data,
  output alu_stat_t                  stat
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [QUO_W-1:0]  quo_r;
  logic signed [Q_W-1:0]    acc_r;
  logic                     sat_r;

  logic signed [Q_W-1:0]    mul_b;
  logic signed [QUO_W-1:0]  quo_nxt;
  logic signed [QUO_W:0]    sum_w;
  logic                     ovf_hi;
  logic                     ovf_lo;
  logic signed [Q_W-1:0]    sum_clamped;

  assign mul_b = ctrl.mul_row ? row_data : operand;

  // Divide by 2^16 rounding toward zero
  assign quo_nxt = prod_r[PROD_W-1:16]
                 + QUO_W'(prod_r[PROD_W-1] && (prod_r[15:0] != 16'd0));

  always_comb begin
    if (ctrl.add_sub) begin
      sum_w = {{(QUO_W-Q_W+1){acc_r[Q_W-1]}}, acc_r} - {quo_r[QUO_W-1], quo_r};
    end else begin
      sum_w = {{(QUO_W-Q_W+1){acc_r[Q_W-1]}}, acc_r} + {quo_r[QUO_W-1], quo_r};
    end
    ovf_hi = !sum_w[QUO_W] && (sum_w[QUO_W-1:Q_W-1] != '0);
    ovf_lo = sum_w[QUO_W] && (sum_w[QUO_W-1:Q_W-1] != '1);
    if (ovf_hi) begin
      sum_clamped = Q_MAX;
    end else if (ovf_lo) begin
      sum_clamped = Q_MIN;
    end else begin
      sum_clamped = sum_w[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= scale * mul_b;
    end
    if (ctrl.quo_en) begin
      quo_r <= quo_nxt;
    end
    if (ctrl.acc_load) begin
      acc_r <= ctrl.acc_row ? row_data : operand;
    end else if (ctrl.add_en) begin
      acc_r <= sum_clamped;
    end
    if (ctrl.sat_clr) begin
      sat_r <= 1'b0;
    end else if (ctrl.add_en) begin
      sat_r <= sat_r | ovf_hi | ovf_lo;
    end
  end

  assign stat.acc = acc_r;
  assign stat.sat = sat_r;
  assign stat.sum = sum_clamped;

endmodule

`default_nettype wire

// ===== src/imvp_seq.sv =====
// ----------------------------------------------------------------------------
// imvp_seq
// Command sequencer: memory accesses, datapath steps and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module imvp_seq
  import imvp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic signed [Q_W-1:0]  operand,
  output logic                   out_valid,
  output out_item_t              out_result,
  output logic                   arc_we,
  output logic [COL_AW-1:0]      arc_waddr,
  output arc_t                   arc_wdata,
  output logic                   arc_re,
  output logic [COL_AW-1:0]      arc_raddr,
  input  wire arc_t              arc_rdata,
  output logic                   row_we,
  output logic [ROW_AW-1:0]      row_waddr,
  output logic signed [Q_W-1:0]  row_wdata,
  output logic                   row_re,
  output logic [ROW_AW-1:0]      row_raddr,
  input  wire logic signed [Q_W-1:0] row_rdata,
  output alu_ctrl_t              alu_ctrl,
  input  wire alu_stat_t         alu_stat
);

  state_t           state_r, state_nxt;
  in_item_t         item_r;
  logic             side_r, side_nxt;
  logic             hm_r, hm_nxt, hp_r, hp_nxt;
  logic [IDX_W-1:0] am_r, am_nxt, ap_r, ap_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             accept;
  logic             is_times;
  logic             cur_has;
  logic [IDX_W-1:0] cur_row;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_times = (item_r.command == CMD_TIMES);
  assign cur_has  = side_r ? hp_r : hm_r;
  assign cur_row  = side_r ? ap_r : am_r;
  assign operand  = item_r.operand_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    side_r <= side_nxt;
    hm_r   <= hm_nxt;
    hp_r   <= hp_nxt;
    am_r   <= am_nxt;
    ap_r   <= ap_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    hm_nxt        = hm_r;
    hp_nxt        = hp_r;
    am_nxt        = am_r;
    ap_nxt        = ap_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    arc_we        = 1'b0;
    arc_waddr     = item_r.column_index[COL_AW-1:0];
    arc_wdata     = '{plus_present:  item_r.plus_present,
                      plus_row:      item_r.plus_row,
                      minus_present: item_r.minus_present,
                      minus_row:     item_r.minus_row};
    arc_re        = 1'b0;
    arc_raddr     = item_r.column_index[COL_AW-1:0];
    row_we        = 1'b0;
    row_waddr     = cur_row[ROW_AW-1:0];
    row_wdata     = alu_stat.sum;
    row_re        = 1'b0;
    row_raddr     = cur_row[ROW_AW-1:0];
    alu_ctrl      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        priority if (item_r.command == CMD_WR_ARC) begin
          arc_we = col_ok(item_r.column_index);
        end else if (item_r.command == CMD_WR_ROW) begin
          row_we    = row_ok(item_r.row_index);
          row_waddr = item_r.row_index[ROW_AW-1:0];
          row_wdata = item_r.operand_value;
        end else if (item_r.command == CMD_RD_ROW) begin
          row_re    = 1'b1;
          row_raddr = item_r.row_index[ROW_AW-1:0];
          state_nxt = S_RDOUT;
        end else if (item_r.command == CMD_TIMES || item_r.command == CMD_TRANS) begin
          arc_re    = 1'b1;
          state_nxt = S_ARC;
        end else begin
          state_nxt = S_IDLE;   // unknown code: no effect, no result
        end
      end
      S_ARC: begin
        // out-of-range column or row reads as an absent entry
        hm_nxt   = col_ok(item_r.column_index) && arc_rdata.minus_present
                   && row_ok(arc_rdata.minus_row);
        hp_nxt   = col_ok(item_r.column_index) && arc_rdata.plus_present
                   && row_ok(arc_rdata.plus_row);
        am_nxt   = arc_rdata.minus_row;
        ap_nxt   = arc_rdata.plus_row;
        side_nxt = 1'b0;
        alu_ctrl.sat_clr = 1'b1;
        if (is_times) begin
          alu_ctrl.mul_en = 1'b1;
          state_nxt       = S_QUO;
        end else begin
          alu_ctrl.acc_load = 1'b1;
          state_nxt         = S_SIDE;
        end
      end
      S_QUO: begin
        alu_ctrl.quo_en = 1'b1;
        state_nxt = is_times ? S_SIDE : S_ADD;
      end
      S_SIDE: begin
        if (cur_has) begin
          row_re    = 1'b1;
          state_nxt = S_ROWD;
        end else if (side_r) begin
          state_nxt = S_DONE;
        end else begin
          side_nxt = 1'b1;
        end
      end
      S_ROWD: begin
        if (is_times) begin
          alu_ctrl.acc_load = 1'b1;
          alu_ctrl.acc_row  = 1'b1;
          state_nxt         = S_ADD;
        end else begin
          alu_ctrl.mul_en  = 1'b1;
          alu_ctrl.mul_row = 1'b1;
          state_nxt        = S_QUO;
        end
      end
      S_ADD: begin
        alu_ctrl.add_en  = 1'b1;
        alu_ctrl.add_sub = !side_r;
        row_we = is_times;
        if (side_r) begin
          state_nxt = S_DONE;
        end else begin
          side_nxt  = 1'b1;
          state_nxt = S_SIDE;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt.result_value = is_times ? '0 : alu_stat.acc;
        out_nxt.saturated    = alu_stat.sat;
        state_nxt = S_IDLE;
      end
      S_RDOUT: begin
        out_valid_nxt = 1'b1;
        out_nxt.result_value = row_ok(item_r.row_index) ? row_rdata : '0;
        out_nxt.saturated    = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

`ifndef ASSERT_OFF
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_DONE || $past(state_r) == S_RDOUT))
    else $error("result strobe without a finishing step");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(arc_we && row_we))
    else $error("both stores written in one cycle");
  a_row_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(row_we && row_re))
    else $error("row store read and written in one cycle");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DISPATCH))
    else $error("accepted command not dispatched");
  a_rd_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && item_r.command == CMD_RD_ROW) |-> !out_r.saturated)
    else $error("row read flagged as saturated");
`endif

endmodule

`default_nettype wire

// ===== src/incidence_matrix_vector_product_unit.sv =====
// ----------------------------------------------------------------------------
// incidence_matrix_vector_product_unit
// Network arc table and row vector with times / transpose products.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: present in_item with start high; the command transfers
//   on the rising edge where start is high and busy is low. busy stays high
//   until the command has finished, then a new command may transfer.
//   Result channel: out_valid pulses for one cycle with out_result. There is
//   no back-pressure; the receiver must take every result.
//   Config channel: cfg_ready is always high; scale_factor (Q16.16) is
//   written on cfg_valid. Write it only while the unit is idle.
// Steps from transfer until busy falls
//   write arc, write row, unknown code : dispatch only
//   read row : dispatch, read-out; strobe in the first cycle with busy low
//   transpose: arc read; per present row: read, multiply, rescale, add/sub
//   times    : multiply, rescale; per present row: read, add/sub, write back
//   One shared multiplier and one saturating adder under the sequencer, and
//   a single row-store port pair, shape these steps: every row access is a
//   read-then-use, and times writes back through the same store.
// Reset: synchronous on rst_n; sequencer idle, scale_factor = 1.0. The arc
//   and row stores are not cleared; reading unwritten entries is undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module incidence_matrix_vector_product_unit
  import imvp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  output out_item_t                  out_result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic signed [Q_W-1:0] cfg_data
);

  // scale register
  logic signed [Q_W-1:0] scale_r;

  // store ports
  logic                  arc_we, arc_re;
  logic [COL_AW-1:0]     arc_waddr, arc_raddr;
  arc_t                  arc_wdata, arc_rdata;
  logic                  row_we, row_re;
  logic [ROW_AW-1:0]     row_waddr, row_raddr;
  logic signed [Q_W-1:0] row_wdata, row_rdata;

  // operand of the held command
  logic signed [Q_W-1:0] seq_operand;

  alu_ctrl_t             alu_ctrl;
  alu_stat_t             alu_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_data;
    end
  end

  // Arc table: one entry per column
  imvp_ram #(
    .WIDTH (ARC_W),
    .DEPTH (COLUMNS)
  ) u_arc_ram (
    .clk     (clk),
    .wr_en   (arc_we),
    .wr_addr (arc_waddr),
    .wr_data (arc_wdata),
    .rd_en   (arc_re),
    .rd_addr (arc_raddr),
    .rd_data (arc_rdata)
  );

  // Row vector
  imvp_ram #(
    .WIDTH (Q_W),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (row_wdata),
    .rd_en   (row_re),
    .rd_addr (row_raddr),
    .rd_data (row_rdata)
  );

  // Shared multiply / rescale / saturating add
  imvp_alu u_alu (
    .clk      (clk),
    .ctrl     (alu_ctrl),
    .scale    (scale_r),
    .operand  (seq_operand),
    .row_data (row_rdata),
    .stat     (alu_stat)
  );

  imvp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .operand    (seq_operand),
    .out_valid  (out_valid),
    .out_result (out_result),
    .arc_we     (arc_we),
    .arc_waddr  (arc_waddr),
    .arc_wdata  (arc_wdata),
    .arc_re     (arc_re),
    .arc_raddr  (arc_raddr),
    .arc_rdata  (arc_rdata),
    .row_we     (row_we),
    .row_waddr  (row_waddr),
    .row_wdata  (row_wdata),
    .row_re     (row_re),
    .row_raddr  (row_raddr),
    .row_rdata  (row_rdata),
    .alu_ctrl   (alu_ctrl),
    .alu_stat   (alu_stat)
  );

endmodule

`default_nettype wire

// ===== tb/tb_incidence_matrix_vector_product_unit.sv =====
// ----------------------------------------------------------------------------
// tb_incidence_matrix_vector_product_unit
// Self-checking bench for the network incidence matrix-vector product unit.
// A short table of hand-picked commands comes first: extreme values, every
// command, arcs with absent rows, an arc whose minus and plus rows coincide,
// and the spare command codes. Random phases follow, one per scale_factor
// setting. Each transfer is mirrored into a behavioural copy of the arc
// table and row vector. Each result strobe is checked against it or a pinned value.
// ----------------------------------------------------------------------------

module tb_incidence_matrix_vector_product_unit;
  import imvp_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 16;   // beyond the slowest command
  localparam int PHASE_ITEMS   = 77;
  localparam int MAX_GAP       = 6;

  // codes beyond read row: the unit must ignore them
  localparam logic [2:0] SPARE_CODE_A = 3'd5;
  localparam logic [2:0] SPARE_CODE_B = 3'd6;
  localparam logic [2:0] SPARE_CODE_C = 3'd7;

  typedef struct {
    in_item_t  item;
    bit        pin;      // expected result typed in below
    out_item_t pinned;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic signed [Q_W-1:0] cfg_data  = '0;

  // pinned expectation travelling with the item on the command port
  bit        pin_flag = 1'b0;
  out_item_t pin_val  = '0;

  // behavioural copy of the unit
  arc_t                  arc_mem [COLUMNS];
  logic signed [Q_W-1:0] row_mem [ROWS];
  logic signed [Q_W-1:0] scale_q = SCALE_RESET;
  bit                    step_sat;

  out_item_t awaited_results [$];
  dir_row_t  dir_tab [$];

  // what the stimulus side has written so far: only these are ever read
  int known_rows [$];
  int known_cols [$];
  bit row_seen [ROWS];
  bit col_seen [COLUMNS];

  int cycles         = 0;
  int mismatches     = 0;
  int commands_done  = 0;
  int results_seen   = 0;
  int sat_results    = 0;
  int scales_written = 0;

  incidence_matrix_vector_product_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Arithmetic of the unit: Q16.16 product truncated toward zero, kept wide,
  // then every sum clamped to 32 bits, each clamp raising the flag.
  // --------------------------------------------------------------------------
  function automatic longint scaled(input logic signed [Q_W-1:0] v);
    return (longint'(scale_q) * longint'(v)) / 64'sd65536;
  endfunction

  function automatic logic signed [Q_W-1:0] saturate(input longint v);
    if (v > longint'(Q_MAX)) begin
      step_sat = 1'b1;
      return Q_MAX;
    end
    if (v < longint'(Q_MIN)) begin
      step_sat = 1'b1;
      return Q_MIN;
    end
    return Q_W'(v);
  endfunction

  // One accepted command applied to the copy; gives the result it causes.
  function automatic void step_network(input in_item_t it, output bit gives,
                                       output out_item_t res);
    arc_t                  a;
    bit                    hm, hp;
    longint                p;
    logic signed [Q_W-1:0] acc;
    gives    = 1'b0;
    res      = '0;
    step_sat = 1'b0;
    a        = '0;
    if (int'(it.column_index) < COLUMNS)
      a = arc_mem[it.column_index];
    hm = a.minus_present && int'(a.minus_row) < ROWS;
    hp = a.plus_present && int'(a.plus_row) < ROWS;
    case (it.command)
      CMD_WR_ARC: begin
        if (int'(it.column_index) < COLUMNS)
          arc_mem[it.column_index] = '{plus_present: it.plus_present,
                                       plus_row: it.plus_row,
                                       minus_present: it.minus_present,
                                       minus_row: it.minus_row};
      end
      CMD_WR_ROW: begin
        if (int'(it.row_index) < ROWS)
          row_mem[it.row_index] = it.operand_value;
      end
      CMD_RD_ROW: begin
        gives = 1'b1;
        if (int'(it.row_index) < ROWS)
          res.result_value = row_mem[it.row_index];
      end
      CMD_TIMES: begin
        // minus side first, so a shared row is clamped twice in order
        p = scaled(it.operand_value);
        if (hm)
          row_mem[a.minus_row] = saturate(longint'(row_mem[a.minus_row]) - p);
        if (hp)
          row_mem[a.plus_row] = saturate(longint'(row_mem[a.plus_row]) + p);
        gives         = 1'b1;
        res.saturated = step_sat;
      end
      CMD_TRANS: begin
        acc = $signed(it.operand_value);
        if (hm)
          acc = saturate(longint'(acc) - scaled(row_mem[a.minus_row]));
        if (hp)
          acc = saturate(longint'(acc) + scaled(row_mem[a.plus_row]));
        gives            = 1'b1;
        res.result_value = acc;
        res.saturated    = step_sat;
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: sample at the rising edge, check strobes, mirror transfers.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    out_item_t pred;
    bit        gives;
    if (!rst_n) begin
      scale_q = SCALE_RESET;
    end else begin
      if (out_valid === 1'b1) begin
        results_seen++;
        if (out_result.saturated === 1'b1)
          sat_results++;
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: result_value %0d saturated %0b",
                 $signed(out_result.result_value), out_result.saturated);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_result.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(want.result_value), $signed(out_result.result_value));
            mismatches++;
          end
          if (out_result.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b",
                   want.saturated, out_result.saturated);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready === 1'b1)
        scale_q = cfg_data;
      if (start && busy === 1'b0) begin
        step_network(in_item, gives, pred);
        if (gives)
          awaited_results.push_back(pin_flag ? pin_val : pred);
        if (in_item.command <= CMD_RD_ROW)
          commands_done++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("incidence_matrix_vector_product_unit test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All driving happens at the falling edge.
  // --------------------------------------------------------------------------
  function automatic void note_item(input in_item_t it);
    if (it.command == CMD_WR_ROW && !row_seen[it.row_index]) begin
      row_seen[it.row_index] = 1'b1;
      known_rows.push_back(int'(it.row_index));
    end
    if (it.command == CMD_WR_ARC && !col_seen[it.column_index]) begin
      col_seen[it.column_index] = 1'b1;
      known_cols.push_back(int'(it.column_index));
    end
  endfunction

  function automatic logic signed [Q_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return ($urandom_range(0, 1) != 0) ? SCALE_RESET : -SCALE_RESET;
      4, 5: return $signed($urandom);
      default: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_known_row();
    return IDX_W'(known_rows[$urandom_range(0, known_rows.size() - 1)]);
  endfunction

  // Mostly well-formed traffic: arcs point at written rows, products and
  // reads touch only written columns and rows. Spare codes are the noise.
  function automatic in_item_t pick_item();
    in_item_t it;
    int       roll;
    it.column_index  = IDX_W'($urandom_range(0, 1023));
    it.minus_row     = IDX_W'($urandom_range(0, 1023));
    it.minus_present = 1'($urandom_range(0, 1));
    it.plus_row      = IDX_W'($urandom_range(0, 1023));
    it.plus_present  = 1'($urandom_range(0, 1));
    it.row_index     = IDX_W'($urandom_range(0, 1023));
    it.operand_value = pick_value();
    roll             = $urandom_range(0, 99);
    if (known_rows.size() == 0 || roll < 18) begin
      it.command = CMD_WR_ROW;
    end else if (known_cols.size() == 0 || roll < 36) begin
      it.command = CMD_WR_ARC;
      if (it.minus_present)
        it.minus_row = pick_known_row();
      if (it.plus_present)
        it.plus_row = ($urandom_range(0, 9) == 0 && it.minus_present) ?
                      it.minus_row : pick_known_row();
    end else if (roll < 97) begin
      it.column_index = IDX_W'(known_cols[$urandom_range(0, known_cols.size() - 1)]);
      it.row_index    = pick_known_row();
      it.command      = (roll < 60) ? CMD_TIMES : (roll < 86) ? CMD_TRANS : CMD_RD_ROW;
    end else begin
      case ($urandom_range(0, 2))
        0:       it.command = SPARE_CODE_A;
        1:       it.command = SPARE_CODE_B;
        default: it.command = SPARE_CODE_C;
      endcase
    end
    return it;
  endfunction

  task automatic add_dir(input logic [2:0] code, input int col, input int mrow,
                         input bit mp, input int prow, input bit pp, input int ridx,
                         input logic signed [Q_W-1:0] value, input bit pin,
                         input logic signed [Q_W-1:0] pres, input bit psat);
    dir_row_t r;
    r.item.command       = code;
    r.item.column_index  = IDX_W'(col);
    r.item.minus_row     = IDX_W'(mrow);
    r.item.minus_present = mp;
    r.item.plus_row      = IDX_W'(prow);
    r.item.plus_present  = pp;
    r.item.row_index     = IDX_W'(ridx);
    r.item.operand_value = value;
    r.pin                = pin;
    r.pinned             = '{result_value: pres, saturated: psat};
    dir_tab.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  // start stays high across back-to-back items.
  task automatic send(input in_item_t it, input bit pin, input out_item_t pinned,
                      input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    pin_flag <= pin;
    pin_val  <= pinned;
    start    <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    note_item(it);
  endtask

  // Write arc and write row give no strobe, so allow for one still running.
  task automatic settle();
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(input logic signed [Q_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    scales_written++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic signed [Q_W-1:0] plan [8];
    in_item_t              it;
    bit                    burst;
    int                    sent;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, run at the reset scale of 1.0.
    //       code          col   mrow mp  prow pp  ridx value        pin  result      sat
    add_dir(CMD_WR_ROW,    0,    0,   0,  0,   0,  0,   Q_MAX,       0,   '0,         0);
    add_dir(CMD_WR_ROW,    0,    0,   0,  0,   0,  1023, Q_MIN,      0,   '0,         0);
    add_dir(CMD_WR_ROW,    0,    0,   0,  0,   0,  5,   SCALE_RESET, 0,   '0,         0);
    add_dir(CMD_RD_ROW,    0,    0,   0,  0,   0,  0,   '0,          1,   Q_MAX,      0);
    add_dir(CMD_RD_ROW,    1023, 1023, 1, 1023, 1, 1023, -1,         1,   Q_MIN,      0);
    add_dir(CMD_WR_ARC,    0,    5,   1,  0,   1,  0,   '0,          0,   '0,         0);
    add_dir(CMD_WR_ARC,    1023, 1023, 1, 0,   1,  0,   '0,          0,   '0,         0);
    add_dir(CMD_WR_ARC,    7,    1023, 0, 1023, 0, 0,   '0,          0,   '0,         0);
    add_dir(CMD_WR_ARC,    9,    5,   1,  0,   0,  0,   '0,          0,   '0,         0);
    add_dir(CMD_WR_ARC,    10,   0,   0,  5,   1,  0,   '0,          0,   '0,         0);
    add_dir(CMD_WR_ARC,    2,    5,   1,  5,   1,  0,   '0,          0,   '0,         0);
    // arc with both rows absent: transpose hands y_in back, times is a no-op
    add_dir(CMD_TRANS,     7,    0,   0,  0,   0,  0,   32'sh1234_5678, 1, 32'sh1234_5678, 0);
    add_dir(CMD_TIMES,     7,    0,   0,  0,   0,  0,   Q_MAX,       1,   '0,         0);
    // 0 - MIN clamps high, adding MAX stays clamped
    add_dir(CMD_TRANS,     1023, 0,   0,  0,   0,  0,   '0,          1,   Q_MAX,      1);
    // row 5 drops to zero, row 0 clamps at MAX
    add_dir(CMD_TIMES,     0,    0,   0,  0,   0,  0,   SCALE_RESET, 1,   '0,         1);
    add_dir(CMD_RD_ROW,    0,    0,   0,  0,   0,  5,   '0,          1,   '0,         0);
    // minus and plus on the same row: subtract, clamp, then add
    add_dir(CMD_TIMES,     2,    0,   0,  0,   0,  0,   Q_MIN,       0,   '0,         0);
    add_dir(CMD_RD_ROW,    0,    0,   0,  0,   0,  5,   '0,          0,   '0,         0);
    add_dir(CMD_TRANS,     9,    0,   0,  0,   0,  0,   Q_MIN,       0,   '0,         0);
    add_dir(CMD_TRANS,     10,   0,   0,  0,   0,  0,   Q_MAX,       0,   '0,         0);
    add_dir(CMD_TRANS,     0,    0,   0,  0,   0,  0,   '0,          0,   '0,         0);
    // spare codes: no strobe, no state change
    add_dir(SPARE_CODE_A,  1023, 1023, 1, 1023, 1, 1023, -1,         0,   '0,         0);
    add_dir(SPARE_CODE_B,  0,    5,   1,  5,   1,  5,   Q_MAX,       0,   '0,         0);
    add_dir(SPARE_CODE_C,  2,    0,   0,  0,   0,  0,   Q_MIN,       0,   '0,         0);
    add_dir(CMD_RD_ROW,    0,    0,   0,  0,   0,  5,   '0,          0,   '0,         0);

    foreach (dir_tab[i])
      send(dir_tab[i].item, dir_tab[i].pin, dir_tab[i].pinned, $urandom_range(0, MAX_GAP));

    // Random phases, one per scale setting, extremes included.
    plan = '{Q_MAX, Q_MIN, 32'sd0, -SCALE_RESET, 32'sh0000_8000, SCALE_RESET,
             $signed($urandom), 32'sd1};
    foreach (plan[p]) begin
      start <= 1'b0;
      settle();
      write_scale(plan[p]);
      burst = ($urandom_range(0, 2) == 0);  // some phases run back to back
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        it = pick_item();
        send(it, 1'b0, '0, burst ? 0 : int'($urandom_range(0, MAX_GAP)));
        if (it.command <= CMD_RD_ROW)
          sent++;
      end
    end

    start <= 1'b0;
    settle();
    mismatches += awaited_results.size();

    $display("Ran %0d commands over %0d written scale settings plus the reset scale.",
             commands_done, scales_written);
    $display("Checked %0d results, %0d of them flagged as clamped.",
             results_seen, sat_results);
    if (mismatches == 0) begin
      $display("incidence_matrix_vector_product_unit test passed");
    end else begin
      $display("incidence_matrix_vector_product_unit test failed");
    end
    $finish;
  end

endmodule
